>>> design/adn_pkg.sv
// Package for the axis dead-zone normalizer: widths, register indexes, defaults.
package adn_pkg;

	localparam int unsigned FRAC_BITS_DEF = 15;
	localparam int unsigned SAMPLE_W      = 32;
	localparam int unsigned DEAD_ZONE_W   = 31;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = 32;

	localparam logic [SAMPLE_W-1:0]    AXIS_MIN_RST  = 32'sd0;
	localparam logic [SAMPLE_W-1:0]    AXIS_MAX_RST  = 32'sd255;
	localparam logic [DEAD_ZONE_W-1:0] DEAD_ZONE_RST = 31'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AXIS_MIN  = 2'd0,
		CFG_AXIS_MAX  = 2'd1,
		CFG_DEAD_ZONE = 2'd2
	} cfg_reg_t;

endpackage

>>> design/axis_deadzone_normalizer.sv
// Axis dead-zone normalizer: pipelined centre/clamp/dead-zone and restoring divider.
//
// Usage:
//   Input channel: raw_sample with in_valid; the block drives in_stall. An item is
//   taken at a rising edge with in_valid high and in_stall low.
//   Output channel: position and in_dead_zone with out_valid; the receiver drives
//   out_stall. An item leaves at a rising edge with out_valid high and out_stall low.
//   Config channel: cfg_index / cfg_data with cfg_valid; cfg_ready is always high.
//   Index 0 axis_min, 1 axis_max, 2 dead_zone; other indexes are ignored. Write only
//   while no items are in flight.
//   Pipeline from input to output: six stages of centre, clamp and dead-zone
//   arithmetic, FRAC_BITS + 1 divider stages with one quotient bit each, and the
//   output register.
//   Throughput: one item per cycle while the output is not stalled.
//   Stall: the whole pipeline holds while a result waits at a stalled output;
//   in_stall is then high and nothing is lost or repeated.
//   Reset: arst_n low clears all valid bits and loads axis_min = 0, axis_max = 255,
//   dead_zone = 0.
module axis_deadzone_normalizer
	import adn_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_W-1:0]    raw_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [FRAC_BITS+1:0]   position,
	output logic                          in_dead_zone,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int unsigned POS_W = FRAC_BITS + 2;
	localparam int unsigned DS    = FRAC_BITS + 1;
	localparam int unsigned RW    = SAMPLE_W + 3;
	localparam int unsigned MW    = SAMPLE_W + 1;

	logic signed [SAMPLE_W-1:0] axis_min_q;
	logic signed [SAMPLE_W-1:0] axis_max_q;
	logic [DEAD_ZONE_W-1:0]     dead_zone_q;

	logic en;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_min_q  <= AXIS_MIN_RST;
			axis_max_q  <= AXIS_MAX_RST;
			dead_zone_q <= DEAD_ZONE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_AXIS_MIN:  axis_min_q  <= cfg_data;
				CFG_AXIS_MAX:  axis_max_q  <= cfg_data;
				CFG_DEAD_ZONE: dead_zone_q <= cfg_data[DEAD_ZONE_W-1:0];
				default: ;
			endcase
		end
	end

	// valid bits of the front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// s1: range sum
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [SAMPLE_W:0]   sum_s1;
	// s2: centre, truncated toward zero
	logic signed [SAMPLE_W-1:0] sample_s2;
	logic signed [SAMPLE_W:0]   centre_s2;
	// s3: offset and half range
	logic signed [SAMPLE_W+1:0] off_s3;
	logic signed [SAMPLE_W+1:0] half_s3;
	// s4: clamped offset
	logic signed [SAMPLE_W+1:0] offc_s4;
	logic signed [SAMPLE_W+1:0] half_s4;
	logic                       hle0_s4;
	// s5: magnitude and divisor
	logic [MW-1:0]              mag_s5;
	logic signed [SAMPLE_W+1:0] den_s5;
	logic                       neg_s5;
	logic                       hle0_s5;
	// s6: numerator and dead-zone flag
	logic [MW-1:0]              num_s6;
	logic [MW-1:0]              den_s6;
	logic                       neg_s6;
	logic                       dzf_s6;

	logic signed [SAMPLE_W+1:0] off_c;
	logic signed [SAMPLE_W+1:0] half_n;
	logic signed [SAMPLE_W+1:0] half_e;
	logic signed [SAMPLE_W+1:0] off_neg;
	logic signed [SAMPLE_W+1:0] dz_e;

	assign half_e  = half_s3;
	assign half_n  = -half_e;
	assign off_neg = -offc_s4;
	assign dz_e    = {3'b000, dead_zone_q};

	always_comb begin
		if (off_s3 > half_s3) begin
			off_c = half_s3;
		end else if (off_s3 < half_n) begin
			off_c = half_n;
		end else begin
			off_c = off_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s1 <= raw_sample;
			sum_s1    <= {axis_min_q[SAMPLE_W-1], axis_min_q}
			           + {axis_max_q[SAMPLE_W-1], axis_max_q};

			sample_s2 <= sample_s1;
			centre_s2 <= $signed(sum_s1 + {{SAMPLE_W{1'b0}}, sum_s1[SAMPLE_W]}) >>> 1;

			off_s3  <= {{2{sample_s2[SAMPLE_W-1]}}, sample_s2}
			         - {centre_s2[SAMPLE_W], centre_s2};
			half_s3 <= {{2{axis_max_q[SAMPLE_W-1]}}, axis_max_q}
			         - {centre_s2[SAMPLE_W], centre_s2};

			offc_s4 <= off_c;
			half_s4 <= half_s3;
			hle0_s4 <= (half_s3 <= 0);

			neg_s5  <= offc_s4[SAMPLE_W+1];
			mag_s5  <= offc_s4[SAMPLE_W+1] ? off_neg[MW-1:0] : offc_s4[MW-1:0];
			den_s5  <= half_s4 - dz_e;
			hle0_s5 <= hle0_s4;

			neg_s6 <= neg_s5;
			dzf_s6 <= hle0_s5 || (mag_s5 <= {2'b00, dead_zone_q});
			num_s6 <= mag_s5 - {2'b00, dead_zone_q};
			den_s6 <= den_s5[MW-1:0];
		end
	end

	// restoring divider, one quotient bit per stage
	logic            dv  [1:DS];
	logic            dneg[1:DS];
	logic            ddzf[1:DS];
	logic [DS-1:0]   dq  [1:DS];
	logic [RW-1:0]   drem[1:DS-1];
	logic [MW-1:0]   dden[1:DS-1];

	for (genvar k = 0; k < DS; k++) begin : g_div
		logic          v_i;
		logic          neg_i;
		logic          dzf_i;
		logic [DS-1:0] q_i;
		logic [RW-1:0] rem_i;
		logic [MW-1:0] den_i;
		logic          ge;
		logic [RW-1:0] den_x;
		logic [RW-1:0] rem_n;

		if (k == 0) begin : g_head
			assign v_i   = v_s6;
			assign neg_i = neg_s6;
			assign dzf_i = dzf_s6;
			assign q_i   = '0;
			assign rem_i = {{(RW-MW){1'b0}}, num_s6};
			assign den_i = den_s6;
		end else begin : g_body
			assign v_i   = dv[k];
			assign neg_i = dneg[k];
			assign dzf_i = ddzf[k];
			assign q_i   = dq[k];
			assign rem_i = drem[k];
			assign den_i = dden[k];
		end

		assign den_x = {{(RW-MW){1'b0}}, den_i};
		assign ge    = rem_i >= den_x;
		assign rem_n = ge ? rem_i - den_x : rem_i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[k+1] <= 1'b0;
			end else if (en) begin
				dv[k+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dneg[k+1] <= neg_i;
				ddzf[k+1] <= dzf_i;
				dq[k+1]   <= {q_i[DS-2:0], ge};
			end
		end

		if (k < DS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					drem[k+1] <= {rem_n[RW-2:0], 1'b0};
					dden[k+1] <= den_i;
				end
			end
		end
	end

	// output register
	logic [POS_W-1:0] q_ext;
	logic [POS_W-1:0] q_neg;
	assign q_ext = {1'b0, dq[DS]};
	assign q_neg = -q_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv[DS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_dead_zone <= ddzf[DS];
			if (ddzf[DS]) begin
				position <= '0;
			end else if (dneg[DS]) begin
				position <= q_neg;
			end else begin
				position <= q_ext;
			end
		end
	end

endmodule
